FILE: rtl/core/bcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_pkg: shared types and helpers for the binomial coefficient block
// Field widths, the saturation marker, the job and status records and the
// saturating Pascal addition.
// ----------------------------------------------------------------------------
package bcp_pkg;

    localparam int N_W       = 7;
    localparam int VALUE_W   = 63;
    localparam int MAX_N_DEF = 66;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_ONE = VALUE_W'(1);

    typedef struct packed {
        logic [N_W-1:0] n;
        logic [N_W-1:0] kk;
    } bcp_job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bcp_status_t;

    // saturate at the out-of-range marker
    function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VALUE_W] ? VALUE_MAX : s[VALUE_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bcp_row_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_row_ram: Pascal row store
// One write port and one registered read port; a read of the entry being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module bcp_row_ram #(
    parameter int DEPTH = 34,
    parameter int AW    = 6
) (
    input  wire                          clk,
    input  wire                          rd_en,
    input  wire  [AW-1:0]                rd_addr,
    output logic [bcp_pkg::VALUE_W-1:0]  rd_data,
    input  wire                          wr_en,
    input  wire  [AW-1:0]                wr_addr,
    input  wire  [bcp_pkg::VALUE_W-1:0]  wr_data
);
    import bcp_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // forward the beat being written
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: rtl/core/bcp_row_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_row_engine: Pascal row sequencer
// Walks rows 1..n, reading entries from top down to 0 and writing back
// row[j] + row[j-1] one entry per cycle until row[kk] of row n is formed.
// ----------------------------------------------------------------------------
module bcp_row_engine #(
    parameter int MAX_N = bcp_pkg::MAX_N_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire  bcp_pkg::bcp_job_t      job,
    output bcp_pkg::bcp_status_t         status,
    output logic [bcp_pkg::VALUE_W-1:0]  result
);
    import bcp_pkg::*;

    localparam int DEPTH = MAX_N / 2 + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [N_W-1:0]     kk_reg, kk_next;
    logic [N_W-1:0]     row_reg, row_next;
    logic [N_W-1:0]     top_reg, top_next;
    logic [N_W-1:0]     addr_reg, addr_next;
    logic               pend_reg, pend_next;
    logic [N_W-1:0]     pend_addr_reg;
    logic [N_W-1:0]     pend_row_reg;
    logic [N_W-1:0]     pend_top_reg;
    logic [VALUE_W-1:0] held_reg, held_next;

    logic               rd_en;
    logic [VALUE_W-1:0] rd_data;
    logic [VALUE_W-1:0] eff;
    logic [VALUE_W-1:0] sum;
    logic [N_W-1:0]     wr_idx;
    logic               wr_en;
    logic               done_now;
    logic [N_W-1:0]     row_inc;

    bcp_row_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (sum)
    );

    always_comb
    begin
        rd_en    = (state_reg == S_RUN);
        // entry 0 is always one; the top entry of a fresh row is zero
        if (pend_addr_reg == '0)
        begin
            eff = VALUE_ONE;
        end
        else if (pend_addr_reg == pend_row_reg)
        begin
            eff = '0;
        end
        else
        begin
            eff = rd_data;
        end
        sum      = sat_add(held_reg, eff);
        wr_idx   = pend_addr_reg + N_W'(1);
        wr_en    = pend_reg && (pend_addr_reg != pend_top_reg);
        done_now = wr_en && (pend_row_reg == n_reg) && (wr_idx == kk_reg);
        held_next = pend_reg ? eff : held_reg;
        row_inc  = row_reg + N_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        kk_next    = kk_reg;
        row_next   = row_reg;
        top_next   = top_reg;
        addr_next  = addr_reg;
        pend_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    n_next     = job.n;
                    kk_next    = job.kk;
                    row_next   = N_W'(1);
                    top_next   = N_W'(1);
                    addr_next  = N_W'(1);
                end
            end
            S_RUN:
            begin
                pend_next = ~done_now;
                if (done_now)
                begin
                    state_next = S_IDLE;
                end
                else if (addr_reg == '0)
                begin
                    // advance to the next row, top clipped at kk
                    row_next  = row_inc;
                    top_next  = (row_inc < kk_reg) ? row_inc : kk_reg;
                    addr_next = (row_inc < kk_reg) ? row_inc : kk_reg;
                end
                else
                begin
                    addr_next = addr_reg - N_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        kk_reg        <= kk_next;
        row_reg       <= row_next;
        top_reg       <= top_next;
        addr_reg      <= addr_next;
        held_reg      <= held_next;
        pend_addr_reg <= addr_reg;
        pend_row_reg  <= row_reg;
        pend_top_reg  <= top_reg;
    end

    assign status.busy = (state_reg == S_RUN);
    assign status.done = done_now;
    assign result      = sum;

endmodule
`default_nettype wire

FILE: rtl/core/binomial_coefficient_pascal_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binomial_coefficient_pascal_top: binomial coefficient C(n,k)
// Decodes the trivial cases at once and builds the rest by Pascal's rule
// in a row memory, one read-add-write per cycle.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// query     in         start & ~busy             n[6:0], k[6:0]
// result    out        done (one-cycle strobe)   value[62:0]
//
// A beat with k above n, k zero, k equal to n, or n above MAX_N answers in
// the cycle after acceptance and leaves busy low. Any other beat sets busy
// and answers once the single read-add-write loop over the row memory has
// formed entry kk = min(k, n-k) of row n. The memory needs no clearing
// pass: entries above the current row read as zero and entry 0 as one.
// Reset clears control only. The receiver cannot stall; done lasts exactly
// one cycle.
// ----------------------------------------------------------------------------
module binomial_coefficient_pascal_top #(
    parameter int MAX_N = bcp_pkg::MAX_N_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire  [bcp_pkg::N_W-1:0]      n,
    input  wire  [bcp_pkg::N_W-1:0]      k,
    output logic                         busy,
    output logic                         done,
    output logic [bcp_pkg::VALUE_W-1:0]  value
);
    import bcp_pkg::*;

    localparam logic [N_W-1:0] MAX_N_V = N_W'(MAX_N);

    bcp_job_t           job;
    bcp_status_t        eng_status;
    logic [VALUE_W-1:0] eng_result;
    logic               accept;
    logic               trivial;
    logic               eng_start;
    logic [VALUE_W-1:0] trivial_value;
    logic [N_W-1:0]     n_minus_k;
    logic               done_reg, done_next;
    logic [VALUE_W-1:0] value_reg, value_next;

    // accept a beat only while the row engine is free
    assign accept    = start & ~eng_status.busy;
    assign n_minus_k = n - k;

    always_comb
    begin
        trivial       = 1'b1;
        trivial_value = '0;
        priority if (k > n)
        begin
            trivial_value = '0;
        end
        else if ((k == '0) || (k == n))
        begin
            trivial_value = VALUE_ONE;
        end
        else if (n > MAX_N_V)
        begin
            // beyond the row memory: report the out-of-range marker
            trivial_value = VALUE_MAX;
        end
        else
        begin
            trivial = 1'b0;
        end
    end

    // fold k onto the short side of the row by symmetry
    assign job.n     = n;
    assign job.kk    = (n_minus_k < k) ? n_minus_k : k;
    assign eng_start = accept & ~trivial;

    bcp_row_engine #(
        .MAX_N (MAX_N)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (eng_start),
        .job    (job),
        .status (eng_status),
        .result (eng_result)
    );

    // register each result with a one-cycle done strobe; trivial answers and engine answers
    // never coincide since the engine holds busy while it runs
    always_comb
    begin
        done_next  = 1'b0;
        value_next = value_reg;
        if (eng_status.done)
        begin
            done_next  = 1'b1;
            value_next = eng_result;
        end
        else if (accept && trivial)
        begin
            done_next  = 1'b1;
            value_next = trivial_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign busy  = eng_status.busy;
    assign done  = done_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

FILE: tb/bcp_tb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_tb_pkg: query record and scoreboard for the binomial coefficient bench
// Predicts C(n,k) for every accepted query beat by building Pascal rows with
// saturation, and checks each returned value against the oldest prediction.
// ----------------------------------------------------------------------------
package bcp_tb_pkg;

    import bcp_pkg::*;

    localparam int CHAIN_ROWS = MAX_N_DEF;

    typedef struct packed {
        logic [N_W-1:0] n;
        logic [N_W-1:0] k;
    } query_t;

    class coeff_scoreboard;

        logic [VALUE_W-1:0] expected_q[$];
        query_t             query_q[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        accepted;
        int unsigned        zero_beats;
        int unsigned        marker_beats;
        int unsigned        pascal_beats;

        // C(n,k) by Pascal's rule, one row at a time, saturating each sum
        function logic [VALUE_W-1:0] pascal_coeff(query_t q);
            logic [VALUE_W:0] row [0:CHAIN_ROWS];
            logic [VALUE_W:0] s;
            int unsigned      kk;
            int unsigned      top;
            int unsigned      i;
            int unsigned      j;
            if (q.k > q.n)
                return '0;
            if (q.k == 0 || q.k == q.n)
                return VALUE_ONE;
            if (q.n > CHAIN_ROWS)
                return VALUE_MAX;
            kk = (q.n - q.k < q.k) ? (q.n - q.k) : q.k;
            for (j = 0; j <= kk; j++)
                row[j] = '0;
            row[0] = 1;
            for (i = 1; i <= q.n; i++)
            begin
                top = (i < kk) ? i : kk;
                for (j = top; j >= 1; j--)
                begin
                    s      = row[j] + row[j-1];
                    row[j] = (s > {1'b0, VALUE_MAX}) ? {1'b0, VALUE_MAX} : s;
                end
            end
            return row[kk][VALUE_W-1:0];
        endfunction

        function void note_query(query_t q);
            expected_q.push_back(pascal_coeff(q));
            query_q.push_back(q);
            accepted++;
            if (q.k > q.n)
                zero_beats++;
            else if (q.k != 0 && q.k != q.n)
            begin
                if (q.n > CHAIN_ROWS)
                    marker_beats++;
                else
                    pascal_beats++;
            end
        endfunction

        function void check_value(logic [VALUE_W-1:0] got);
            logic [VALUE_W-1:0] want;
            query_t             q;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result value=%0d with no query outstanding", got);
                return;
            end
            want = expected_q.pop_front();
            q    = query_q.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: n=%0d k=%0d value expected %0d got %0d",
                             q.n, q.k, want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage
`default_nettype wire

FILE: tb/binomial_coefficient_pascal_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binomial_coefficient_pascal_top_tb: self-checking bench for C(n,k)
// Drives query beats through the start/busy handshake, predicts every answer
// with a Pascal-row scoreboard and checks each done strobe in order. A short
// corner list is followed by a weighted random mix with bursts of idling.
// ----------------------------------------------------------------------------
module binomial_coefficient_pascal_top_tb;

    import bcp_pkg::*;
    import bcp_tb_pkg::*;

    // Random part of the run and the stretch at its end with no idling
    localparam int RANDOM_BEATS  = 1100;
    localparam int QUIET_TAIL    = 150;
    // Worst single query: n = 66, k = 33
    localparam int SLOWEST_BEAT  = 1700;
    // Every beat at its slowest, with the longest sender gap, four times over
    localparam int CYCLE_LIMIT   = 4 * (RANDOM_BEATS + 40) * (SLOWEST_BEAT + 10);
    // Trivial answers come in the cycle after acceptance; allow a margin
    localparam int SETTLE_CYCLES = 20;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [N_W-1:0]      n;
    logic [N_W-1:0]      k;
    logic                busy;
    logic                done;
    logic [VALUE_W-1:0]  value;

    coeff_scoreboard     sb;
    int unsigned         cycles;
    bit                  idle_on;

    binomial_coefficient_pascal_top #(
        .MAX_N (CHAIN_ROWS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .n     (n),
        .k     (k),
        .busy  (busy),
        .done  (done),
        .value (value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every done strobe; the receiver cannot stall, so take each one
    // at the edge that closes its cycle. Values read here are pre-edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_value(value);
    end

    // Watchdog: end the run if the handshakes stop making progress
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycles, sb.pending());
        $display("binomial_coefficient_pascal_top_tb NOT OK");
        $finish;
    end

    // Present one query beat and hold it until the block takes it. Busy is
    // sampled right after the edge, so it still shows the pre-edge value.
    task automatic send_query(input query_t q);
        start <= 1'b1;
        n     <= q.n;
        k     <= q.k;
        do
            @(posedge clk);
        while (busy);
        sb.note_query(q);
    endtask

    // Drop start for a random burst on 35 percent of calls, when idling is enabled
    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 99) < 35)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Hold off new beats until every outstanding answer has come back
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        query_t      corner_q[$];
        query_t      q;
        int          rn;
        int          rk;
        int unsigned i;

        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        n     = '0;
        k     = '0;
        idle_on = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners: empty set, k above n, k zero and k equal to n, the widest
        // row in the chain, n beyond the chain, and all-ones fields
        corner_q = '{
            {7'd0,   7'd0},   {7'd0,   7'd1},   {7'd1,   7'd0},   {7'd1,   7'd1},
            {7'd2,   7'd1},   {7'd10,  7'd3},   {7'd10,  7'd7},   {7'd3,   7'd4},
            {7'd66,  7'd33},  {7'd66,  7'd1},   {7'd66,  7'd65},  {7'd66,  7'd66},
            {7'd66,  7'd0},   {7'd66,  7'd67},  {7'd65,  7'd32},  {7'd67,  7'd1},
            {7'd67,  7'd66},  {7'd67,  7'd67},  {7'd127, 7'd127}, {7'd127, 7'd0},
            {7'd127, 7'd1},   {7'd127, 7'd126}, {7'd0,   7'd127}, {7'd5,   7'd127}
        };
        foreach (corner_q[c])
        begin
            send_query(corner_q[c]);
            sender_gap();
        end

        // Let the block run dry before the random part
        drain_results();

        for (i = 0; i < RANDOM_BEATS; i++)
        begin
            // Switch idling on and off in stretches; none near the end
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 2) != 0) && (i < RANDOM_BEATS - QUIET_TAIL);
            if (i == RANDOM_BEATS / 2)
                drain_results();

            // Weighted mix: mostly short Pascal runs, some long rows, and
            // the trivial and out-of-range answers
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    rn = $urandom_range(0, 16);
                    rk = $urandom_range(0, rn + 1);
                end
                4, 5:
                begin
                    rn = $urandom_range(17, CHAIN_ROWS);
                    rk = $urandom_range(1, rn - 1);
                end
                6:
                begin
                    rn = $urandom_range(0, 126);
                    rk = $urandom_range(rn + 1, 127);
                end
                7:
                begin
                    rn = $urandom_range(CHAIN_ROWS + 1, 127);
                    rk = $urandom_range(0, 127);
                end
                8:
                begin
                    rn = $urandom_range(0, 127);
                    rk = $urandom_range(0, 1) ? 0 : rn;
                end
                default:
                begin
                    rn = $urandom;
                    rk = $urandom;
                end
            endcase
            q = {N_W'(rn), N_W'(rk)};

            send_query(q);
            sender_gap();
        end

        // Wait for the last answers, then watch for stray strobes
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d queries: %0d by Pascal rows, %0d with k above n,",
                 sb.accepted, sb.pascal_beats, sb.zero_beats);
        $display("%0d beyond the chain; checked %0d values, %0d mismatches",
                 sb.marker_beats, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("binomial_coefficient_pascal_top_tb OK");
        else
            $display("binomial_coefficient_pascal_top_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
